// File: rtl/core/msc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Line state codes shared by the coherence block and its testbench.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam logic [2:0] ST_I = 3'd0;
  localparam logic [2:0] ST_M = 3'd1;
  localparam logic [2:0] ST_O = 3'd2;
  localparam logic [2:0] ST_E = 3'd3;
  localparam logic [2:0] ST_S = 3'd4;
  localparam logic [2:0] ST_F = 3'd5;

endpackage
`default_nettype wire

// File: rtl/core/moesif_snoop_coherence_four_cores.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// moesif_snoop_coherence_four_cores
// Snooping MOESIF coherence over NUM_CORES fully associative caches.
//
// Usage: one transaction on the in_ channel names a core, read or write and a
// tag. One result transaction on the out_ channel reports hit, broadcast,
// writebacks, cache-to-cache transfer, the new line state and the way used.
// All lines live in one synchronous memory, one row per core (all ways of a
// core side by side), with a registered read port.
// Sequence: the sequencer reads NUM_CORES+1 rows, one per cycle: the
// requester's row, the other cores' rows in core order (each modified and
// written back in the cycle after its read), then the requester's row
// again to install or update the line. One transaction is in work at a time.
// Reset: a clearing pass writes every row to invalid with LRU rank equal to
// the way number; in_ready stays low meanwhile.
// Stall: a finished result is held in the output registers until taken; the
// next transaction is not accepted until the result is taken.
// ----------------------------------------------------------------------------
module moesif_snoop_coherence_four_cores
  import msc_pkg::*;
#(
  parameter int NUM_CORES = 4,
  parameter int NUM_WAYS  = 4,
  parameter int TAG_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_core_id,
  input  wire logic        in_action,
  input  wire logic [31:0] in_address_tag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic             out_broadcast,
  output logic [2:0]       out_writebacks,
  output logic             out_transfer,
  output logic [2:0]       out_new_state,
  output logic [1:0]       out_way_used
);

  localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int NW = $clog2(NUM_CORES + 2);
  localparam logic [NW-1:0] LAST_RD   = NW'(NUM_CORES);
  localparam logic [NW-1:0] LAST_STEP = NW'(NUM_CORES + 1);

  typedef struct packed {
    logic [2:0]          st;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
    logic [WW-1:0]       rank;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] row_t;

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_RUN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // Cache memory: one row per core
  row_t          mem [NUM_CORES];
  row_t          rd_q;
  logic [CW-1:0] rd_addr;
  logic          we;
  logic [CW-1:0] wr_addr;
  row_t          wr_data;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_t              state_r, state_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       req_c_r;
  logic                req_wr_r;
  logic [TAG_BITS-1:0] req_tag_r;
  logic                rd_pend_r;
  logic [NW-1:0]       rd_seq_r;
  logic [CW-1:0]       rd_core_r;
  // snoop summary gathered over the pass
  logic                hit_r, inv_r, held_r;
  logic                bc_r, xfer_r;
  logic [2:0]          wb_r, nst_r;
  logic [WW-1:0]       way_r;

  // Requester first, then the other cores in order, then the requester again
  function automatic logic [CW-1:0] seq_core(logic [NW-1:0] idx, logic [CW-1:0] rc);
    logic [NW-1:0] oth;
    oth = idx - 1'b1;
    if (idx == '0 || idx >= LAST_RD) return rc;
    if (oth < NW'(rc)) return CW'(oth);
    return CW'(idx);
  endfunction

  // Fold the core number into range
  logic [1:0] core_mod;
  assign core_mod = (32'(in_core_id) >= 32'(NUM_CORES)) ? in_core_id - 2'(NUM_CORES)
                                                          : in_core_id;

  // Snoop the row just read: lowest matching way
  logic          row_hit;
  logic [WW-1:0] row_way;
  logic [2:0]    row_st;
  always_comb begin
    row_hit = 1'b0;
    row_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_q[w].st != ST_I && rd_q[w].tag == req_tag_r) begin
        row_hit = 1'b1;
        row_way = WW'(w);
      end
    end
  end
  assign row_st = rd_q[row_way].st;

  // Pick the fill way: lowest invalid way, else lowest way with rank zero
  logic [WW-1:0] victim;
  always_comb begin
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_q[w].rank == '0) victim = WW'(w);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rd_q[w].st == ST_I) victim = WW'(w);
    end
  end

  // Modify another core's row: invalidate copies or downgrade the supplier
  row_t       oth_row;
  logic [3:0] oth_wb;
  always_comb begin
    oth_row = rd_q;
    oth_wb  = 4'd0;
    if (inv_r) begin
      for (int k = 0; k < NUM_WAYS; k++) begin
        if (rd_q[k].st != ST_I && rd_q[k].tag == req_tag_r) begin
          if (rd_q[k].dirty) oth_wb = oth_wb + 4'd1;
          oth_row[k].st    = ST_I;
          oth_row[k].dirty = 1'b0;
        end
      end
    end else if (!req_wr_r && !hit_r && !held_r && row_hit) begin
      case (row_st)
        ST_M: begin
          oth_row[row_way].st    = ST_O;
          oth_row[row_way].dirty = 1'b1;
        end
        ST_E: begin
          oth_row[row_way].st    = ST_F;
          oth_row[row_way].dirty = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Modify the requester's row: fill or upgrade, then advance LRU order
  row_t          req_row;
  logic [3:0]    req_wb;
  logic [WW-1:0] req_way;
  logic [WW-1:0] req_cur;
  always_comb begin
    req_row = rd_q;
    req_wb  = 4'd0;
    req_way = hit_r ? way_r : victim;
    req_cur = rd_q[req_way].rank;
    if (!hit_r) begin
      if (rd_q[req_way].st != ST_I && rd_q[req_way].dirty) req_wb = 4'd1;
      req_row[req_way].tag   = req_tag_r;
      req_row[req_way].st    = req_wr_r ? ST_M : (held_r ? ST_S : ST_E);
      req_row[req_way].dirty = req_wr_r;
    end else if (req_wr_r) begin
      req_row[req_way].st    = ST_M;
      req_row[req_way].dirty = 1'b1;
    end
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (rd_q[k].rank > req_cur) req_row[k].rank = rd_q[k].rank - 1'b1;
    end
    req_row[req_way].rank = WW'(NUM_WAYS - 1);
  end

  // Select the row and writeback count of the current step
  logic       last_rd;
  row_t       upd_row;
  logic [3:0] step_wb;
  logic [4:0] wb_sum;
  assign last_rd = (rd_seq_r == LAST_RD);
  assign upd_row = last_rd ? req_row : oth_row;
  assign step_wb = last_rd ? req_wb : oth_wb;
  assign wb_sum  = {2'b00, wb_r} + {1'b0, step_wb};

  // Sequencer: clear, wait, read and write back rows, hold the result
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = rd_core_r;
    wr_data   = upd_row;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wr_addr = CW'(cnt_r);
        for (int w = 0; w < NUM_WAYS; w++) begin
          wr_data[w].st    = ST_I;
          wr_data[w].dirty = 1'b0;
          wr_data[w].tag   = '0;
          wr_data[w].rank  = WW'(w);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(NUM_CORES - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
          cnt_nxt   = '0;
        end
      end
      S_RUN: begin
        if (cnt_r <= LAST_RD) rd_addr = seq_core(cnt_r, req_c_r);
        if (rd_pend_r && rd_seq_r != '0) we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= (state_r == S_RUN) && (cnt_r <= LAST_RD);
    end
  end

  // Capture the request, gather snoop results and settle the outcome
  always_ff @(posedge clk) begin
    rd_seq_r  <= cnt_r;
    rd_core_r <= rd_addr;
    if (state_r == S_IDLE && in_valid) begin
      req_c_r   <= CW'(core_mod);
      req_wr_r  <= in_action;
      req_tag_r <= in_address_tag[TAG_BITS-1:0];
      held_r    <= 1'b0;
      wb_r      <= 3'd0;
    end
    if (rd_pend_r) begin
      if (rd_seq_r == '0) begin
        hit_r <= row_hit;
        way_r <= row_way;
        bc_r  <= !(row_hit && row_st == ST_E);
        inv_r <= req_wr_r && (!row_hit || (row_st inside {ST_S, ST_F, ST_O}));
      end else begin
        wb_r <= (wb_sum > 5'd7) ? 3'd7 : wb_sum[2:0];
        if (last_rd) begin
          way_r  <= req_way;
          nst_r  <= req_row[req_way].st;
          xfer_r <= !hit_r && !req_wr_r && held_r;
        end else if (row_hit) begin
          held_r <= 1'b1;
        end
      end
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_hit        = hit_r;
  assign out_broadcast  = bc_r;
  assign out_writebacks = wb_r;
  assign out_transfer   = xfer_r;
  assign out_new_state  = nst_r;
  assign out_way_used   = 2'(way_r);

endmodule
`default_nettype wire
